/* hdl/rau_pkg.sv */
`timescale 1ns / 1ps
package rau_pkg;

  localparam int OperandWidthDefault = 32;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4,
    MODE_RED = 3'd5
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Classified work handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  status;
    logic        do_reduce;
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] bn;
    logic [63:0] bd;
  } task_t;

endpackage

/* hdl/rau_if.sv */
`timescale 1ns / 1ps
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [63:0] res_den;
  logic [1:0]  order;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, order, status, input ready);
  modport sink (input valid, res_num, res_den, order, status, output ready);
endinterface

/* hdl/rational_arith_unit.sv */
`timescale 1ns / 1ps
// Without reduction an accepted word passes the front register, the queue and the
// back end's multiply and combine states to a result; with reduction each Euclid step
// takes one pass through the shared bit-serial divider, followed by two final divisions.
// The back end handles one item at a time, and the two-entry queue lets the front
// accept while it works.
// Reset (rst, synchronous): queues and handshakes empty, reduce_results set to 1.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  logic  reduce_results;
  logic  fv, fr, qv, qr;
  task_t fd, qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_results <= 1'b1;
    end else if (cfg_we) begin
      reduce_results <= cfg_wdata;
    end
  end

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst, .in_ch, .reduce_results, .tv(fv), .tr(fr), .tdata(fd)
  );
  rau_queue u_queue (
    .clk, .rst, .iv(fv), .ir(fr), .idata(fd), .ov(qv), .orr(qr), .odata(qd)
  );
  rau_back u_back (
    .clk, .rst, .tv(qv), .tr(qr), .tdata(qd), .out_ch
  );
endmodule

/* hdl/rau_front.sv */
`timescale 1ns / 1ps
module rau_front #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input  logic               clk,
  input  logic               rst,
  rau_in_if.sink             in_ch,
  input  logic               reduce_results,
  output logic               tv,
  input  logic               tr,
  output rau_pkg::task_t     tdata
);
  import rau_pkg::*;

  logic [63:0] an, ad, bn, bd;
  logic [1:0]  status;
  logic        red;
  logic [2:0]  mode;

  function automatic logic [63:0] sext(input logic [31:0] x);
    return 64'(signed'(x[OPERAND_WIDTH-1:0]));
  endfunction

  always_comb begin
    mode = in_ch.mode;
    an = sext(in_ch.a_num);
    ad = sext(in_ch.a_den);
    bn = sext(in_ch.b_num);
    bd = sext(in_ch.b_den);
    status = ST_OK;
    if (mode <= 3'(MODE_CMP)) begin
      if (ad == '0 || bd == '0 || (mode == 3'(MODE_DIV) && bn == '0)) begin
        status = ST_ZERO;
      end
    end else if (mode == 3'(MODE_RED)) begin
      if (ad == '0) begin
        status = ST_ZERO;
      end
    end
    red = (mode == 3'(MODE_RED)) || (mode <= 3'(MODE_DIV) && reduce_results);
  end

  // Single output register; it refills in the cycle it drains.
  assign in_ch.ready = !tv || tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tv <= 1'b1;
        tdata <= '{mode: mode, status: status, do_reduce: red,
                   an: an, ad: ad, bn: bn, bd: bd};
      end else if (tr) begin
        tv <= 1'b0;
      end
    end
  end
endmodule

/* hdl/rau_queue.sv */
`timescale 1ns / 1ps
module rau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           iv,
  output logic           ir,
  input  rau_pkg::task_t idata,
  output logic           ov,
  input  logic           orr,
  output rau_pkg::task_t odata
);
  import rau_pkg::*;

  localparam int AW = $clog2(QueueDepth);

  task_t         mem [QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign ir = cnt != (AW+1)'(QueueDepth);
  assign ov = cnt != '0;
  assign odata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (iv && ir) begin
        mem[wp] <= idata;
        wp <= wp + 1'b1;
      end
      if (ov && orr) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(iv && ir) - (AW+1)'(ov && orr);
    end
  end

  a_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(QueueDepth)) else $error("queue count over depth");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == (AW+1)'(QueueDepth) && !orr) |=> !ir) else $error("full queue opened");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 && !iv) |=> !ov) else $error("empty queue shows data");
endmodule

/* hdl/rau_back.sv */
`timescale 1ns / 1ps
module rau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           tv,
  output logic           tr,
  input  rau_pkg::task_t tdata,
  rau_out_if.source      out_ch
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  state_t      state;
  task_t       t;
  logic [63:0] p1, p2, p3, rn, rd;
  logic [63:0] gx, gy;
  logic [1:0]  status, order;
  // Unsigned restoring divider, one quotient bit per cycle.
  logic [63:0] dv_q, dv_r, dv_d;
  logic        dv_nq, dv_nr;
  logic [6:0]  dv_cnt;
  logic        dv_busy;
  logic [1:0]  dv_use;  // 0 gcd remainder, 1 numerator, 2 denominator
  logic [64:0] trial;
  logic        is_mul, is_div;

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  // Operands are sign-extended from at most 32 bits, so a 32 by 32 product is exact.
  function automatic logic [63:0] smul(input logic [63:0] x, input logic [63:0] y);
    return 64'($signed(x[31:0]) * $signed(y[31:0]));
  endfunction

  assign tr = (state == S_IDLE);
  assign trial = {dv_r, dv_q[63]} - {1'b0, dv_d};
  assign is_mul = (t.mode == 3'(MODE_MUL));
  assign is_div = (t.mode == 3'(MODE_DIV));

  logic signed [64:0] s_add, s_sub;
  assign s_add = 65'($signed(p1)) + 65'($signed(p2));
  assign s_sub = 65'($signed(p1)) - 65'($signed(p2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      dv_busy <= 1'b0;
      dv_d <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      if (dv_busy) begin
        dv_q <= {dv_q[62:0], !trial[64]};
        dv_r <= trial[64] ? {dv_r[62:0], dv_q[63]} : trial[63:0];
        dv_cnt <= dv_cnt - 1'b1;
        if (dv_cnt == 7'd1) begin
          dv_busy <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (tv) begin
            t <= tdata;
            status <= tdata.status;
            order <= ORD_LESS;
            rn <= '0;
            rd <= '0;
            state <= (tdata.status == ST_OK) ? S_MUL1 : S_DONE;
          end
        end
        S_MUL1: begin
          p1 <= smul(t.an, t.bd);
          state <= S_MUL2;
        end
        S_MUL2: begin
          // Multiply needs ad * bd here instead of the cross product.
          p2 <= smul(is_mul ? t.ad : t.bn, is_mul ? t.bd : t.ad);
          state <= S_MUL3;
        end
        S_MUL3: begin
          p3 <= smul(is_mul ? t.an : t.ad, (is_mul || is_div) ? t.bn : t.bd);
          state <= S_COMB;
        end
        S_COMB: begin
          case (t.mode)
            3'(MODE_ADD): begin
              if (s_add[64] != s_add[63]) begin
                status <= ST_OVF;
                state <= S_DONE;
              end else begin
                state <= t.do_reduce ? S_GCD : S_DONE;
              end
              rn <= s_add[63:0];
              gx <= s_add[63:0];
              rd <= p3;
              gy <= p3;
            end
            3'(MODE_SUB): begin
              if (s_sub[64] != s_sub[63]) begin
                status <= ST_OVF;
                state <= S_DONE;
              end else begin
                state <= t.do_reduce ? S_GCD : S_DONE;
              end
              rn <= s_sub[63:0];
              gx <= s_sub[63:0];
              rd <= p3;
              gy <= p3;
            end
            3'(MODE_MUL), 3'(MODE_DIV): begin
              state <= t.do_reduce ? S_GCD : S_DONE;
              rn <= is_mul ? p3 : p1;
              gx <= is_mul ? p3 : p1;
              rd <= is_mul ? p2 : p3;
              gy <= is_mul ? p2 : p3;
            end
            3'(MODE_CMP): begin
              state <= S_DONE;
              if (p1 == p2) begin
                order <= ORD_EQUAL;
              end else if (($signed(p1) > $signed(p2)) != (t.ad[63] != t.bd[63])) begin
                order <= ORD_GREATER;
              end else begin
                order <= ORD_LESS;
              end
            end
            3'(MODE_RED): begin
              state <= t.do_reduce ? S_GCD : S_DONE;
              rn <= t.an;
              gx <= t.an;
              rd <= t.ad;
              gy <= t.ad;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_GCD: begin
          // One remainder per pass through the divider; gx holds g at the end.
          if (!dv_busy) begin
            if (dv_use == 2'd0 && dv_cnt == '0 && !dv_nq && dv_d != '0) begin
              gx <= gy;
              gy <= dv_nr ? -dv_r : dv_r;
              dv_d <= '0;
            end else if (gy == '0) begin
              if ((gx == '1 && rn == 64'h8000_0000_0000_0000)
                  || (gx == '1 && rd == 64'h8000_0000_0000_0000)) begin
                status <= ST_OVF;
                state <= S_DONE;
              end else begin
                dv_busy <= 1'b1;
                dv_use <= 2'd1;
                dv_cnt <= 7'd64;
                dv_q <= mag(rn);
                dv_r <= '0;
                dv_d <= mag(gx);
                dv_nq <= rn[63] ^ gx[63];
                state <= S_DIVN;
              end
            end else begin
              dv_busy <= 1'b1;
              dv_use <= 2'd0;
              dv_cnt <= 7'd64;
              dv_q <= mag(gx);
              dv_r <= '0;
              dv_d <= mag(gy);
              dv_nq <= 1'b0;
              dv_nr <= gx[63];
            end
          end
        end
        S_DIVN: begin
          if (!dv_busy) begin
            rn <= dv_nq ? -dv_q : dv_q;
            dv_busy <= 1'b1;
            dv_use <= 2'd2;
            dv_cnt <= 7'd64;
            dv_q <= mag(rd);
            dv_r <= '0;
            dv_nq <= rd[63] ^ gx[63];
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (!dv_busy) begin
            rd <= dv_nq ? -dv_q : dv_q;
            dv_use <= 2'd0;
            dv_d <= '0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.status <= status;
            out_ch.res_num <= (status == ST_OK) ? rn : '0;
            out_ch.res_den <= (status == ST_OK) ? rd : '0;
            out_ch.order <= (status == ST_OK) ? order : ORD_LESS;
            dv_d <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_take: assert property (@(posedge clk) disable iff (rst)
    (tv && tr) |=> state != S_IDLE) else $error("item dropped");
  a_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !dv_busy) else $error("divider busy when idle");
  a_err: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.res_num == '0 && out_ch.res_den == '0))
    else $error("error word carries data");
endmodule
